[hw/rtl/dvru_pkg.sv]
// ----------------------------------------------------------------------------
// dvru_pkg
// Shared types and constants of the distance-vector route update unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dvru_pkg;

  // Default sizing of the route table.
  localparam int NODES_DEF     = 16;
  localparam int COST_BITS_DEF = 32;

  // Fixed field widths on the ports.
  localparam int NODE_ID_W  = 4;
  localparam int FUNC_W     = 2;
  localparam int IN_COST_W  = 32;
  localparam int OUT_COST_W = 32;
  localparam int CONV_W     = 5;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // A dump emits at most this many routes.
  localparam int MAX_ROUTES = 16;
  localparam int SENT_W     = 5;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes (address bit 2).
  localparam logic [0:0] REG_SELF_ID        = 1'b0;
  localparam logic [0:0] REG_CONVERGE_COUNT = 1'b1;

  localparam logic [NODE_ID_W-1:0] SELF_ID_RST        = 4'd0;
  localparam logic [CONV_W-1:0]    CONVERGE_COUNT_RST = 5'd8;

  // Request function codes.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_LINK  = 2'd0,
    FUNC_ADV   = 2'd1,
    FUNC_START = 2'd2
  } func_e;

  // Operation handed from front to back.
  typedef enum logic [1:0] {
    OP_LINK,
    OP_ADV,
    OP_START
  } op_e;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADV,
    ST_DUMP,
    ST_DLOAD
  } back_state_e;

  // Classified request, without its cost.
  typedef struct packed {
    op_e                  op;
    logic [NODE_ID_W-1:0] nb;
    logic [NODE_ID_W-1:0] dst;
    logic                 last;
    logic                 nb_ok;
    logic                 dst_ok;
  } item_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/dvru_ram.sv]
// ----------------------------------------------------------------------------
// dvru_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dvru_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[hw/rtl/dvru_front.sv]
// ----------------------------------------------------------------------------
// dvru_front
// Accepts requests, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module dvru_front #(
  parameter int NODES     = dvru_pkg::NODES_DEF,
  parameter int COST_BITS = dvru_pkg::COST_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [dvru_pkg::FUNC_W-1:0]        func_i,
  input  wire logic [dvru_pkg::NODE_ID_W-1:0]     neighbor_i,
  input  wire logic [dvru_pkg::NODE_ID_W-1:0]     destination_i,
  input  wire logic [dvru_pkg::IN_COST_W-1:0]     cost_i,
  input  wire logic                               last_entry_i,
  output logic                                    q_valid_o,
  output dvru_pkg::item_ctrl_t                    q_ctrl_o,
  output logic      [COST_BITS-1:0]               q_cost_o,
  input  wire logic                               q_pop_i
);

  localparam int Depth = dvru_pkg::QUEUE_DEPTH;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);
  localparam int CostW = COST_BITS;

  dvru_pkg::item_ctrl_t ctrl_q [Depth];
  logic [COST_BITS-1:0] cost_q [Depth];
  logic [PtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]      cnt_q, cnt_d;

  dvru_pkg::item_ctrl_t new_ctrl;
  logic                 keep;
  logic                 push;
  logic                 pop;

  always_comb begin
    new_ctrl.nb     = neighbor_i;
    new_ctrl.dst    = destination_i;
    new_ctrl.last   = last_entry_i;
    new_ctrl.nb_ok  = 32'(neighbor_i) < NODES;
    new_ctrl.dst_ok = 32'(destination_i) < NODES;
    new_ctrl.op     = dvru_pkg::OP_LINK;
    keep            = 1'b1;
    unique case (func_i)
      dvru_pkg::FUNC_LINK:  new_ctrl.op = dvru_pkg::OP_LINK;
      dvru_pkg::FUNC_ADV:   new_ctrl.op = dvru_pkg::OP_ADV;
      dvru_pkg::FUNC_START: new_ctrl.op = dvru_pkg::OP_START;
      default:              keep = 1'b0;
    endcase
  end

  assign in_stall_o = (cnt_q == CntW'(Depth));
  // Requests with the unused function code are taken and dropped here.
  assign push       = in_valid_i && !in_stall_o && keep;
  assign pop        = q_pop_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + CntW'(push) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ctrl_q[wr_ptr_q] <= new_ctrl;
      cost_q[wr_ptr_q] <= CostW'(cost_i);
    end
  end

  assign q_valid_o = (cnt_q != '0);
  assign q_ctrl_o  = ctrl_q[rd_ptr_q];
  assign q_cost_o  = cost_q[rd_ptr_q];

endmodule

`default_nettype wire

[hw/rtl/dvru_back.sv]
// ----------------------------------------------------------------------------
// dvru_back
// Route table sequencer: applies link and advertisement requests to the
// table memories and walks the table to emit route dumps.
// ----------------------------------------------------------------------------
`default_nettype none

module dvru_back #(
  parameter int NODES     = dvru_pkg::NODES_DEF,
  parameter int COST_BITS = dvru_pkg::COST_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic [dvru_pkg::NODE_ID_W-1:0]     self_id_i,
  input  wire logic [dvru_pkg::CONV_W-1:0]        converge_count_i,
  input  wire logic                               q_valid_i,
  input  wire dvru_pkg::item_ctrl_t               q_ctrl_i,
  input  wire logic [COST_BITS-1:0]               q_cost_i,
  output logic                                    q_pop_o,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic      [dvru_pkg::NODE_ID_W-1:0]     route_destination_o,
  output logic      [dvru_pkg::OUT_COST_W-1:0]    route_cost_o,
  output logic      [dvru_pkg::NODE_ID_W-1:0]     route_next_hop_o,
  output logic                                    converged_o,
  output logic                                    last_route_o
);

  localparam int NodeW  = $clog2(NODES);
  localparam int CntW   = $clog2(NODES + 1);
  localparam int IdW    = dvru_pkg::NODE_ID_W;
  localparam int OutW   = dvru_pkg::OUT_COST_W;
  localparam int SentW  = dvru_pkg::SENT_W;
  localparam int MaxOut = dvru_pkg::MAX_ROUTES;
  localparam int BestW  = COST_BITS + IdW;

  dvru_pkg::back_state_e state_q, state_d;

  dvru_pkg::item_ctrl_t cur_ctrl_q;
  logic [COST_BITS-1:0] cur_cost_q;
  logic [NODES-1:0]     route_valid_q, route_valid_d;
  logic [NODES-1:0]     link_valid_q, link_valid_d;
  logic [CntW-1:0]      valid_cnt_q, valid_cnt_d;
  logic                 table_changed_q, table_changed_d;
  logic                 converged_q, converged_d;
  logic [CntW-1:0]      walk_q, walk_d;
  logic [SentW-1:0]     sent_q, sent_d;

  logic                 out_valid_q, out_valid_d;
  logic [IdW-1:0]       out_dst_q;
  logic [OutW-1:0]      out_cost_q;
  logic [IdW-1:0]       out_nh_q;
  logic                 out_conv_q;
  logic                 out_last_q;
  logic                 out_load;

  // Table memories.
  logic                 best_we, link_we;
  logic [NodeW-1:0]     best_waddr, best_raddr, link_waddr, link_raddr;
  logic [BestW-1:0]     best_wdata, best_rdata;
  logic [COST_BITS-1:0] link_wdata, link_rdata;

  logic [NodeW-1:0]     head_nb_a, head_dst_a, cur_nb_a, cur_dst_a, walk_a, self_a;
  logic                 self_ok;
  logic [NODES-1:0]     one_hot0, own_mask, known_mask, above_mask;
  logic                 walk_done, walk_known, walk_self, more_known, sent_full;
  logic                 out_free;

  logic [COST_BITS-1:0] link_val, cand, best_cost_rd;
  logic [COST_BITS:0]   sum;
  logic                 replace;
  logic [CntW-1:0]      known;

  dvru_ram #(.WIDTH(BestW), .DEPTH(NODES)) u_best_ram (
    .clk_i   (clk_i),
    .we_i    (best_we),
    .waddr_i (best_waddr),
    .wdata_i (best_wdata),
    .raddr_i (best_raddr),
    .rdata_o (best_rdata)
  );

  dvru_ram #(.WIDTH(COST_BITS), .DEPTH(NODES)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  // Address and mask helpers.
  always_comb begin
    head_nb_a  = NodeW'(q_ctrl_i.nb);
    head_dst_a = NodeW'(q_ctrl_i.dst);
    cur_nb_a   = NodeW'(cur_ctrl_q.nb);
    cur_dst_a  = NodeW'(cur_ctrl_q.dst);
    walk_a     = NodeW'(walk_q);
    self_a     = NodeW'(self_id_i);
    self_ok    = 32'(self_id_i) < NODES;
    one_hot0   = {{(NODES - 1){1'b0}}, 1'b1};
    own_mask   = self_ok ? (one_hot0 << self_a) : '0;
    known_mask = route_valid_q | own_mask;
    above_mask = ~((one_hot0 << walk_a) | ((one_hot0 << walk_a) - one_hot0));
    walk_done  = (walk_q == CntW'(NODES));
    walk_known = !walk_done && known_mask[walk_a];
    walk_self  = self_ok && (walk_a == self_a);
    more_known = |(known_mask & above_mask);
    sent_full  = (sent_q == SentW'(MaxOut));
    out_free   = !out_valid_q || !out_stall_i;
  end

  // Candidate cost of an advertised entry: link cost plus advertised cost,
  // saturating at all ones. An unset link counts as zero.
  always_comb begin
    link_val     = link_valid_q[cur_nb_a] ? link_rdata : '0;
    sum          = {1'b0, link_val} + {1'b0, cur_cost_q};
    cand         = sum[COST_BITS] ? '1 : sum[COST_BITS-1:0];
    best_cost_rd = best_rdata[BestW-1:IdW];
    replace      = cur_ctrl_q.nb_ok && cur_ctrl_q.dst_ok &&
                   (cur_ctrl_q.dst != self_id_i) &&
                   (!route_valid_q[cur_dst_a] || (cand < best_cost_rd));
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dvru_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          unique case (q_ctrl_i.op)
            dvru_pkg::OP_ADV:   state_d = dvru_pkg::ST_ADV;
            dvru_pkg::OP_START: state_d = dvru_pkg::ST_DUMP;
            default:            state_d = dvru_pkg::ST_IDLE;
          endcase
        end
      end
      dvru_pkg::ST_ADV: begin
        if (cur_ctrl_q.last && (table_changed_q || replace)) begin
          state_d = dvru_pkg::ST_DUMP;
        end else begin
          state_d = dvru_pkg::ST_IDLE;
        end
      end
      dvru_pkg::ST_DUMP: begin
        priority if (walk_done || sent_full) begin
          state_d = dvru_pkg::ST_IDLE;
        end else if (walk_known) begin
          state_d = dvru_pkg::ST_DLOAD;
        end else begin
          state_d = dvru_pkg::ST_DUMP;
        end
      end
      dvru_pkg::ST_DLOAD: begin
        if (out_free) begin
          state_d = dvru_pkg::ST_DUMP;
        end
      end
      default: state_d = dvru_pkg::ST_IDLE;
    endcase
  end

  // Datapath and table updates.
  always_comb begin
    q_pop_o         = (state_q == dvru_pkg::ST_IDLE);
    route_valid_d   = route_valid_q;
    link_valid_d    = link_valid_q;
    valid_cnt_d     = valid_cnt_q;
    table_changed_d = table_changed_q;
    converged_d     = converged_q;
    walk_d          = walk_q;
    sent_d          = sent_q;
    out_load        = 1'b0;
    known           = '0;

    best_we    = 1'b0;
    best_waddr = head_nb_a;
    best_wdata = {q_cost_i, q_ctrl_i.nb};
    best_raddr = (state_q == dvru_pkg::ST_IDLE) ? head_dst_a : walk_a;
    link_we    = 1'b0;
    link_waddr = head_nb_a;
    link_wdata = q_cost_i;
    link_raddr = head_nb_a;

    unique case (state_q)
      dvru_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          if (q_ctrl_i.op == dvru_pkg::OP_LINK && q_ctrl_i.nb_ok) begin
            link_we                 = 1'b1;
            link_valid_d[head_nb_a] = 1'b1;
            // A link to this node itself never alters the own route.
            if (q_ctrl_i.nb != self_id_i) begin
              best_we = 1'b1;
              route_valid_d[head_nb_a] = 1'b1;
              if (!route_valid_q[head_nb_a]) begin
                valid_cnt_d = valid_cnt_q + CntW'(1);
              end
            end
          end
          if (q_ctrl_i.op == dvru_pkg::OP_START) begin
            walk_d = '0;
            sent_d = '0;
          end
        end
      end
      dvru_pkg::ST_ADV: begin
        best_waddr = cur_dst_a;
        best_wdata = {cand, cur_ctrl_q.nb};
        if (replace) begin
          best_we                  = 1'b1;
          route_valid_d[cur_dst_a] = 1'b1;
          if (!route_valid_q[cur_dst_a]) begin
            valid_cnt_d = valid_cnt_q + CntW'(1);
          end
        end
        if (cur_ctrl_q.last) begin
          // Known routes after this entry, the own route included.
          known = valid_cnt_d + CntW'(self_ok && !route_valid_d[self_a]);
          if (32'(known) >= 32'(converge_count_i)) begin
            converged_d = 1'b1;
          end
          table_changed_d = 1'b0;
          walk_d          = '0;
          sent_d          = '0;
        end else if (replace) begin
          table_changed_d = 1'b1;
        end
      end
      dvru_pkg::ST_DUMP: begin
        if (!walk_done && !sent_full && !walk_known) begin
          walk_d = walk_q + CntW'(1);
        end
      end
      dvru_pkg::ST_DLOAD: begin
        if (out_free) begin
          out_load = 1'b1;
          walk_d   = walk_q + CntW'(1);
          sent_d   = sent_q + SentW'(1);
        end
      end
      default: ;
    endcase

    out_valid_d = (out_valid_q && out_stall_i) || out_load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= dvru_pkg::ST_IDLE;
      route_valid_q   <= '0;
      link_valid_q    <= '0;
      valid_cnt_q     <= '0;
      table_changed_q <= 1'b0;
      converged_q     <= 1'b0;
      walk_q          <= '0;
      sent_q          <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q         <= state_d;
      route_valid_q   <= route_valid_d;
      link_valid_q    <= link_valid_d;
      valid_cnt_q     <= valid_cnt_d;
      table_changed_q <= table_changed_d;
      converged_q     <= converged_d;
      walk_q          <= walk_d;
      sent_q          <= sent_d;
      out_valid_q     <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == dvru_pkg::ST_IDLE && q_valid_i) begin
      cur_ctrl_q <= q_ctrl_i;
      cur_cost_q <= q_cost_i;
    end
    if (out_load) begin
      out_dst_q  <= IdW'(walk_q);
      out_cost_q <= walk_self ? '0 : OutW'(best_cost_rd);
      out_nh_q   <= walk_self ? self_id_i : best_rdata[IdW-1:0];
      out_conv_q <= converged_q;
      out_last_q <= !more_known || (sent_q == SentW'(MaxOut - 1));
    end
  end

  assign out_valid_o         = out_valid_q;
  assign route_destination_o = out_dst_q;
  assign route_cost_o        = out_cost_q;
  assign route_next_hop_o    = out_nh_q;
  assign converged_o         = out_conv_q;
  assign last_route_o        = out_last_q;

endmodule

`default_nettype wire

[hw/rtl/distance_vector_route_update_unit.sv]
// ----------------------------------------------------------------------------
// distance_vector_route_update_unit
// Distance-vector routing table engine with an APB configuration port.
// ----------------------------------------------------------------------------
// Requests enter a two-deep queue and are carried out one at a time by a
// table sequencer built around two RAMs (best cost with next hop, and link
// cost). An advertisement entry first reads both RAMs, then adds, compares
// and writes back. A dump walks the destinations in order, skips those
// without a route and loads each route into the output register, waiting
// while the output is stalled. The output register lets the next request
// proceed while the final route of a dump waits to be taken.
`default_nettype none

module distance_vector_route_update_unit #(
  parameter int NODES     = dvru_pkg::NODES_DEF,
  parameter int COST_BITS = dvru_pkg::COST_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [dvru_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [dvru_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic      [dvru_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                    pready,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [dvru_pkg::FUNC_W-1:0]        func_i,
  input  wire logic [dvru_pkg::NODE_ID_W-1:0]     neighbor_i,
  input  wire logic [dvru_pkg::NODE_ID_W-1:0]     destination_i,
  input  wire logic [dvru_pkg::IN_COST_W-1:0]     cost_i,
  input  wire logic                               last_entry_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic      [dvru_pkg::NODE_ID_W-1:0]     route_destination_o,
  output logic      [dvru_pkg::OUT_COST_W-1:0]    route_cost_o,
  output logic      [dvru_pkg::NODE_ID_W-1:0]     route_next_hop_o,
  output logic                                    converged_o,
  output logic                                    last_route_o
);

  localparam int DataW = dvru_pkg::CFG_DATA_W;
  localparam int IdW   = dvru_pkg::NODE_ID_W;
  localparam int ConvW = dvru_pkg::CONV_W;

  logic [IdW-1:0]   self_id_q;
  logic [ConvW-1:0] converge_count_q;
  logic             cfg_we;

  logic                 q_valid;
  dvru_pkg::item_ctrl_t q_ctrl;
  logic [COST_BITS-1:0] q_cost;
  logic                 q_pop;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_id_q        <= dvru_pkg::SELF_ID_RST;
      converge_count_q <= dvru_pkg::CONVERGE_COUNT_RST;
    end else if (cfg_we) begin
      unique case (paddr[2:2])
        dvru_pkg::REG_SELF_ID:        self_id_q        <= pwdata[IdW-1:0];
        dvru_pkg::REG_CONVERGE_COUNT: converge_count_q <= pwdata[ConvW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2:2])
      dvru_pkg::REG_SELF_ID:        prdata = DataW'(self_id_q);
      dvru_pkg::REG_CONVERGE_COUNT: prdata = DataW'(converge_count_q);
      default:                      prdata = '0;
    endcase
  end

  dvru_front #(.NODES(NODES), .COST_BITS(COST_BITS)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .neighbor_i    (neighbor_i),
    .destination_i (destination_i),
    .cost_i        (cost_i),
    .last_entry_i  (last_entry_i),
    .q_valid_o     (q_valid),
    .q_ctrl_o      (q_ctrl),
    .q_cost_o      (q_cost),
    .q_pop_i       (q_pop)
  );

  dvru_back #(.NODES(NODES), .COST_BITS(COST_BITS)) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .self_id_i           (self_id_q),
    .converge_count_i    (converge_count_q),
    .q_valid_i           (q_valid),
    .q_ctrl_i            (q_ctrl),
    .q_cost_i            (q_cost),
    .q_pop_o             (q_pop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .route_destination_o (route_destination_o),
    .route_cost_o        (route_cost_o),
    .route_next_hop_o    (route_next_hop_o),
    .converged_o         (converged_o),
    .last_route_o        (last_route_o)
  );

endmodule

`default_nettype wire

[tb/tb_distance_vector_route_update_unit.sv]
// ----------------------------------------------------------------------------
// tb_distance_vector_route_update_unit
// Self-checking testbench for the distance-vector route update unit.
// ----------------------------------------------------------------------------
// A route table tracker follows every accepted request and queues the routes
// that each dump has to produce. Every route taken from the block is compared
// field by field with the oldest queued route. A short directed section covers
// cost extremes, saturation, ties, the own route, unset links and the unused
// function code. Random advertisement sequences follow, mixed with stray
// entries, link updates and starts. Both sides insert random gaps and stalls.
// The configuration changes between phases, while the block is idle.
// ----------------------------------------------------------------------------

module tb_distance_vector_route_update_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FUNC_W     = dvru_pkg::FUNC_W;
  localparam int NODE_ID_W  = dvru_pkg::NODE_ID_W;
  localparam int IN_COST_W  = dvru_pkg::IN_COST_W;
  localparam int OUT_COST_W = dvru_pkg::OUT_COST_W;
  localparam int CONV_W     = dvru_pkg::CONV_W;
  localparam int CFG_ADDR_W = dvru_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W = dvru_pkg::CFG_DATA_W;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int NODE_COUNT     = 16;
  localparam int SETTLE_CYCLES  = 64;
  localparam int DRAIN_CYCLES   = 100;
  localparam int HOLD_CYCLES    = 300;
  localparam int IDLE_LIMIT     = 2000;

  typedef struct packed {
    logic [FUNC_W-1:0]    func;
    logic [NODE_ID_W-1:0] nb;
    logic [NODE_ID_W-1:0] dst;
    logic [IN_COST_W-1:0] cost;
    logic                 last;
  } dv_request_t;

  typedef struct packed {
    logic [NODE_ID_W-1:0]  dest;
    logic [OUT_COST_W-1:0] cost;
    logic [NODE_ID_W-1:0]  hop;
    logic                  conv;
    logic                  last;
  } route_t;

  // Mirrors the routing table and holds the routes still owed by the block.
  class route_table_tracker;
    logic [NODE_ID_W-1:0] self_id;
    logic [CONV_W-1:0]    converge_count;
    bit                   route_known [NODE_COUNT];
    logic [31:0]          best_cost [NODE_COUNT];
    logic [NODE_ID_W-1:0] best_hop [NODE_COUNT];
    logic [31:0]          link_cost [NODE_COUNT];
    bit                   table_dirty;
    bit                   converged;
    route_t               expected_routes [$];
    int                   errors;
    int                   requests;
    int                   routes_checked;
    int                   dumps;

    function new();
      self_id        = dvru_pkg::SELF_ID_RST;
      converge_count = dvru_pkg::CONVERGE_COUNT_RST;
      foreach (route_known[d]) begin
        route_known[d] = 1'b0;
        best_cost[d]   = '0;
        best_hop[d]    = '0;
        link_cost[d]   = '0;
      end
      table_dirty    = 1'b0;
      converged      = 1'b0;
      errors         = 0;
      requests       = 0;
      routes_checked = 0;
      dumps          = 0;
    endfunction

    function void write_register(logic [0:0] index, logic [31:0] value);
      if (index == dvru_pkg::REG_SELF_ID) begin
        self_id = value[NODE_ID_W-1:0];
      end else begin
        converge_count = value[CONV_W-1:0];
      end
    endfunction

    function bit is_known(int d);
      return (d == self_id) || route_known[d];
    endfunction

    function int pending();
      return expected_routes.size();
    endfunction

    // Queue every known route in ascending destination order.
    function void queue_dump();
      route_t dump [$];
      route_t r;
      for (int d = 0; d < NODE_COUNT; d++) begin
        if (is_known(d)) begin
          r.dest = NODE_ID_W'(d);
          r.cost = (d == self_id) ? '0 : best_cost[d];
          r.hop  = (d == self_id) ? self_id : best_hop[d];
          r.conv = converged;
          r.last = 1'b0;
          dump = {dump, r};
        end
      end
      if (dump.size() > 0) begin
        dump[dump.size()-1].last = 1'b1;
        dumps++;
      end
      expected_routes = {expected_routes, dump};
    endfunction

    function void apply_request(dv_request_t r);
      logic [32:0] sum;
      logic [31:0] candidate;
      int          known;
      requests++;
      case (r.func)
        dvru_pkg::FUNC_LINK: begin
          link_cost[r.nb] = r.cost;
          if (r.nb != self_id) begin
            best_cost[r.nb]   = r.cost;
            best_hop[r.nb]    = r.nb;
            route_known[r.nb] = 1'b1;
          end
        end
        dvru_pkg::FUNC_START: begin
          queue_dump();
        end
        dvru_pkg::FUNC_ADV: begin
          if (r.dst != self_id) begin
            sum       = {1'b0, link_cost[r.nb]} + {1'b0, r.cost};
            candidate = sum[32] ? '1 : sum[31:0];
            if (!route_known[r.dst] || candidate < best_cost[r.dst]) begin
              best_cost[r.dst]   = candidate;
              best_hop[r.dst]    = r.nb;
              route_known[r.dst] = 1'b1;
              table_dirty        = 1'b1;
            end
          end
          if (r.last) begin
            known = 0;
            for (int d = 0; d < NODE_COUNT; d++) begin
              if (is_known(d)) known++;
            end
            if (known >= converge_count) converged = 1'b1;
            if (table_dirty) queue_dump();
            table_dirty = 1'b0;
          end
        end
        default: ;
      endcase
    endfunction

    function void report_mismatch(string field, logic [31:0] exp_v, logic [31:0] got_v);
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_v, got_v);
      errors++;
    endfunction

    function void check_route(route_t got);
      route_t exp;
      if (expected_routes.size() == 0) begin
        $display("%0t: unexpected route, expected none, actual dest %0d cost %h hop %0d",
                 $time, got.dest, got.cost, got.hop);
        errors++;
        return;
      end
      exp = expected_routes.pop_front();
      routes_checked++;
      if (got.dest !== exp.dest) begin
        report_mismatch("route_destination", 32'(exp.dest), 32'(got.dest));
      end
      if (got.cost !== exp.cost) report_mismatch("route_cost", exp.cost, got.cost);
      if (got.hop !== exp.hop) report_mismatch("route_next_hop", 32'(exp.hop), 32'(got.hop));
      if (got.conv !== exp.conv) report_mismatch("converged", 32'(exp.conv), 32'(got.conv));
      if (got.last !== exp.last) report_mismatch("last_route", 32'(exp.last), 32'(got.last));
    endfunction

    function void report_leftovers();
      if (expected_routes.size() > 0) begin
        $display("%0t: %0d routes never arrived, expected dest %0d, actual none",
                 $time, expected_routes.size(), expected_routes[0].dest);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [FUNC_W-1:0]     func_i;
  logic [NODE_ID_W-1:0]  neighbor_i;
  logic [NODE_ID_W-1:0]  destination_i;
  logic [IN_COST_W-1:0]  cost_i;
  logic                  last_entry_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [NODE_ID_W-1:0]  route_destination_o;
  logic [OUT_COST_W-1:0] route_cost_o;
  logic [NODE_ID_W-1:0]  route_next_hop_o;
  logic                  converged_o;
  logic                  last_route_o;

  route_table_tracker tracker = new();
  bit tx_gaps_on  = 1'b1;
  bit rx_gaps_on  = 1'b1;
  bit rx_hold_req = 1'b0;
  int settings_written = 0;

  distance_vector_route_update_unit dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .func_i              (func_i),
    .neighbor_i          (neighbor_i),
    .destination_i       (destination_i),
    .cost_i              (cost_i),
    .last_entry_i        (last_entry_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .route_destination_o (route_destination_o),
    .route_cost_o        (route_cost_o),
    .route_next_hop_o    (route_next_hop_o),
    .converged_o         (converged_o),
    .last_route_o        (last_route_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic dv_request_t make_req(logic [FUNC_W-1:0] func, logic [NODE_ID_W-1:0] nb,
                                           logic [NODE_ID_W-1:0] dst, logic [31:0] cost,
                                           logic last);
    dv_request_t r;
    r.func = func;
    r.nb   = nb;
    r.dst  = dst;
    r.cost = cost;
    r.last = last;
    return r;
  endfunction

  // Mostly small costs so that sums stay comparable, with some near saturation.
  function automatic logic [31:0] rand_cost();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 32'h0008_0000);
      1: return $urandom;
      2: return 32'hFFFF_FFFF - $urandom_range(0, 15);
      default: return $urandom_range(0, 15) << 16;
    endcase
  endfunction

  task automatic apb_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_register(input logic [0:0] index, input logic [31:0] value);
    logic [31:0] readback;
    logic [31:0] stored;
    apb_access(1'b1, {index, 2'b00}, value, readback);
    tracker.write_register(index, value);
    settings_written++;
    apb_access(1'b0, {index, 2'b00}, '0, readback);
    stored = (index == dvru_pkg::REG_SELF_ID) ? 32'(tracker.self_id) :
                                                32'(tracker.converge_count);
    if (readback !== stored) begin
      $display("%0t: register %0d readback mismatch, expected %h, actual %h",
               $time, index, stored, readback);
      tracker.errors++;
    end
  endtask

  // Valid only drops when a gap is drawn, so back-to-back requests keep it high.
  task automatic send_request(input dv_request_t r);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= r.func;
    neighbor_i    <= r.nb;
    destination_i <= r.dst;
    cost_i        <= r.cost;
    last_entry_i  <= r.last;
    do @(posedge clk_i); while (in_stall_o);
    tracker.apply_request(r);
  endtask

  task automatic wait_routes_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.pending() > 0);
  endtask

  // Requests that produce no route may still be in flight after the last route.
  task automatic settle();
    wait_routes_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_traffic(input int count);
    int                   sent;
    int                   kind;
    int                   len;
    logic [NODE_ID_W-1:0] nb;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        nb  = NODE_ID_W'($urandom_range(0, NODE_COUNT - 1));
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++) begin
          send_request(make_req(dvru_pkg::FUNC_ADV, nb,
                                NODE_ID_W'($urandom_range(0, NODE_COUNT - 1)), rand_cost(),
                                i == len - 1));
        end
        sent += len;
      end else if (kind < 75) begin
        send_request(make_req(dvru_pkg::FUNC_LINK, NODE_ID_W'($urandom_range(0, NODE_COUNT - 1)),
                              NODE_ID_W'($urandom), rand_cost(), 1'($urandom_range(0, 1))));
        sent++;
      end else if (kind < 85) begin
        send_request(make_req(dvru_pkg::FUNC_START, NODE_ID_W'($urandom), NODE_ID_W'($urandom),
                              $urandom, 1'($urandom_range(0, 1))));
        sent++;
      end else if (kind < 93) begin
        send_request(make_req(dvru_pkg::FUNC_ADV, NODE_ID_W'($urandom), NODE_ID_W'($urandom),
                              rand_cost(), 1'($urandom_range(0, 1))));
        sent++;
      end else begin
        send_request(make_req(FUNC_UNUSED, NODE_ID_W'($urandom), NODE_ID_W'($urandom),
                              $urandom, 1'($urandom_range(0, 1))));
      end
      if ($urandom_range(0, 24) == 0) tx_gaps_on = ~tx_gaps_on;
      if ($urandom_range(0, 24) == 0) rx_gaps_on = ~rx_gaps_on;
    end
  endtask

  initial begin : route_receiver
    int wait_cycles;
    out_stall_i <= 1'b0;
    forever begin
      if (rx_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end
      wait_cycles = rx_gaps_on ? $urandom_range(0, 11) : 0;
      if (wait_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_cycles) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o && !rx_hold_req);
    end
  end

  always @(posedge clk_i) begin : route_monitor
    route_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.dest = route_destination_o;
      got.cost = route_cost_o;
      got.hop  = route_next_hop_o;
      got.conv = converged_o;
      got.last = last_route_o;
      tracker.check_route(got);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (psel && penable) || !rst_ni) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    bit saved_gaps;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid_i    = 1'b0;
    func_i        = dvru_pkg::FUNC_LINK;
    neighbor_i    = '0;
    destination_i = '0;
    cost_i        = '0;
    last_entry_i  = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // High threshold: only a few routes exist here, so the flag stays clear.
    write_register(dvru_pkg::REG_SELF_ID, 32'd3);
    write_register(dvru_pkg::REG_CONVERGE_COUNT, 32'd16);
    send_request(make_req(dvru_pkg::FUNC_START, 4'd0, 4'd0, 32'h0, 1'b0));
    send_request(make_req(FUNC_UNUSED, 4'd5, 4'd6, 32'h1234, 1'b1));
    // Neighbor 9 has no link cost yet, so it counts as zero.
    send_request(make_req(dvru_pkg::FUNC_ADV, 4'd9, 4'd0, 32'h0001_8000, 1'b1));
    send_request(make_req(dvru_pkg::FUNC_LINK, 4'd0, 4'd0, 32'h0, 1'b0));
    send_request(make_req(dvru_pkg::FUNC_LINK, 4'd15, 4'd0, 32'hFFFF_FFFF, 1'b0));
    send_request(make_req(dvru_pkg::FUNC_ADV, 4'd15, 4'd7, 32'h1, 1'b0));
    send_request(make_req(dvru_pkg::FUNC_ADV, 4'd15, 4'd3, 32'h0, 1'b0));
    send_request(make_req(dvru_pkg::FUNC_ADV, 4'd0, 4'd7, 32'hFFFF_FFFE, 1'b0));
    // An equal cost is not an improvement, yet the advertisement changed things.
    send_request(make_req(dvru_pkg::FUNC_ADV, 4'd0, 4'd7, 32'hFFFF_FFFE, 1'b1));
    send_request(make_req(dvru_pkg::FUNC_ADV, 4'd0, 4'd7, 32'hFFFF_FFFF, 1'b1));
    send_request(make_req(dvru_pkg::FUNC_LINK, 4'd3, 4'd0, 32'h0001_0000, 1'b0));
    send_request(make_req(dvru_pkg::FUNC_ADV, 4'd3, 4'd12, 32'h5, 1'b1));
    send_request(make_req(dvru_pkg::FUNC_LINK, 4'd7, 4'd0, 32'h0002_0000, 1'b0));
    send_request(make_req(dvru_pkg::FUNC_ADV, 4'd15, 4'd2, 32'hFFFF_FFFF, 1'b1));
    send_request(make_req(dvru_pkg::FUNC_START, 4'hF, 4'hF, 32'hFFFF_FFFF, 1'b1));
    settle();

    // Zero threshold converges at the first last entry, even without a change.
    write_register(dvru_pkg::REG_SELF_ID, 32'd15);
    write_register(dvru_pkg::REG_CONVERGE_COUNT, 32'd0);
    send_request(make_req(dvru_pkg::FUNC_ADV, 4'd4, 4'd15, 32'h0, 1'b1));
    send_request(make_req(dvru_pkg::FUNC_START, 4'd0, 4'd0, 32'h0, 1'b0));
    send_request(make_req(dvru_pkg::FUNC_LINK, 4'd15, 4'd0, 32'h0000_1234, 1'b0));
    send_request(make_req(dvru_pkg::FUNC_ADV, 4'd15, 4'd1, 32'h10, 1'b1));
    random_traffic(60);
    settle();

    write_register(dvru_pkg::REG_SELF_ID, 32'd0);
    write_register(dvru_pkg::REG_CONVERGE_COUNT, $urandom_range(1, 15));
    random_traffic(30);
    // Hold the output while start requests keep coming so the block backs up.
    rx_hold_req = 1'b1;
    saved_gaps  = tx_gaps_on;
    tx_gaps_on  = 1'b0;
    repeat (6) begin
      send_request(make_req(dvru_pkg::FUNC_START, NODE_ID_W'($urandom), NODE_ID_W'($urandom),
                            $urandom, 1'b0));
    end
    tx_gaps_on = saved_gaps;
    random_traffic(30);
    wait_routes_drained();
    random_traffic(10);
    settle();

    write_register(dvru_pkg::REG_SELF_ID, $urandom_range(0, 15));
    write_register(dvru_pkg::REG_CONVERGE_COUNT, $urandom_range(0, 16));
    random_traffic(60);

    wait_routes_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    tracker.report_leftovers();
    $display("Checked %0d routes in %0d dumps from %0d requests under %0d register writes.",
             tracker.routes_checked, tracker.dumps, tracker.requests, settings_written);
    $display("Mismatches found: %0d", tracker.errors);
    if (tracker.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
